>>> sv/dbhr_pkg.sv
// Package of shared types and constants for the button debounce, hold and repeat block.
package dbhr_pkg;

  // Width of the hold threshold and repeat period registers and of the counters.
  localparam int unsigned CNT_W = 16;

  // Reset values of the two configuration registers.
  localparam logic [CNT_W-1:0] HOLD_RESET   = 16'd300;
  localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd100;

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD  = 1'b1;

  // Operation codes carried by an input beat.
  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_ACK  = 1'b1
  } op_t;

  // Control from the top level to one button lane for the current beat.
  typedef struct packed {
    logic tick;
    logic ack;
  } lane_ctl_t;

  // What one lane reports for the beat: state after the beat and the acknowledge hit.
  typedef struct packed {
    logic pressed;
    logic long_hold;
    logic hit;
  } lane_res_t;

endpackage

>>> sv/dbhr_lane.sv
// One button lane: two-sample debounce, hold counter with long flag, repeat counter with flag.
module dbhr_lane
  import dbhr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lane_ctl_t        ctl,
  input  logic             pin,
  input  logic [CNT_W-1:0] hold_threshold,
  input  logic [CNT_W-1:0] repeat_period,
  output lane_res_t        res
);

  logic             newest_r, newest_nxt;
  logic             older_r, older_nxt;
  logic             stable_r, stable_nxt;
  logic [CNT_W-1:0] hold_cnt_r, hold_cnt_nxt;
  logic [CNT_W-1:0] rep_cnt_r, rep_cnt_nxt;
  logic             long_r, long_nxt;
  logic             rep_flag_r, rep_flag_nxt;
  logic             hit;

  // Next state for a tick or an acknowledge aimed at this lane.
  always_comb begin
    newest_nxt   = newest_r;
    older_nxt    = older_r;
    stable_nxt   = stable_r;
    hold_cnt_nxt = hold_cnt_r;
    rep_cnt_nxt  = rep_cnt_r;
    long_nxt     = long_r;
    rep_flag_nxt = rep_flag_r;
    hit          = 1'b0;
    if (ctl.tick) begin
      // Shift the sample pair; the stable level follows once both samples agree.
      older_nxt  = newest_r;
      newest_nxt = pin;
      if (pin == newest_r) begin
        stable_nxt = pin;
      end
      if (!stable_nxt) begin
        if (hold_cnt_r < hold_threshold) begin
          hold_cnt_nxt = hold_cnt_r + 1'b1;
        end else begin
          long_nxt = 1'b1;
          if (rep_cnt_r < repeat_period) begin
            rep_cnt_nxt = rep_cnt_r + 1'b1;
          end else begin
            rep_flag_nxt = 1'b1;
          end
        end
      end else begin
        hold_cnt_nxt = '0;
        long_nxt     = 1'b0;
      end
    end else if (ctl.ack && rep_flag_r) begin
      // Acknowledge of a set flag clears the flag and restarts the repeat count.
      rep_flag_nxt = 1'b0;
      rep_cnt_nxt  = '0;
      hit          = 1'b1;
    end
  end

  // Lane state registers; released pins reset to one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r   <= 1'b1;
      older_r    <= 1'b1;
      stable_r   <= 1'b1;
      hold_cnt_r <= '0;
      rep_cnt_r  <= PERIOD_RESET;
      long_r     <= 1'b0;
      rep_flag_r <= 1'b0;
    end else begin
      newest_r   <= newest_nxt;
      older_r    <= older_nxt;
      stable_r   <= stable_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
      long_r     <= long_nxt;
      rep_flag_r <= rep_flag_nxt;
    end
  end

  // The report shows the state after the beat.
  assign res.pressed   = ~stable_nxt;
  assign res.long_hold = long_nxt;
  assign res.hit       = hit;

endmodule

>>> sv/button_debounce_hold_repeat.sv
// Top level: configuration registers, one lane per button, merge stage and output register.
//
//   channel | ports                                             | direction
//   --------+---------------------------------------------------+----------
//   input   | in_valid, in_stall, in_operation, in_raw_levels,  | in
//           | in_button_index                                   |
//   result  | out_valid, out_stall, out_pressed_bits,           | out
//           | out_long_hold_bits, out_repeat_hit, out_status    |
//   config  | cfg_wr_en, cfg_index, cfg_wr_data                 | in
//
// The button lanes update in parallel in the cycle of
// acceptance and the merged result is loaded into the output register at that edge.
// One beat is accepted per cycle while the output register is empty or being taken.
// in_stall is high only while a result waits in the output register under out_stall.
// Synchronous reset releases all buttons, clears hold counts and flags, loads the repeat
// counts with PERIOD_RESET and loads the register defaults; no clearing pass is needed.
module button_debounce_hold_repeat
  import dbhr_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic [NUM_BUTTONS-1:0]               in_raw_levels,
  input  logic [$clog2(NUM_BUTTONS+1)-1:0]     in_button_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [NUM_BUTTONS-1:0]               out_pressed_bits,
  output logic [NUM_BUTTONS-1:0]               out_long_hold_bits,
  output logic                                 out_repeat_hit,
  output logic                                 out_status,
  input  logic                                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [CNT_W-1:0]                     cfg_wr_data
);

  localparam int unsigned IDX_W = $clog2(NUM_BUTTONS + 1);

  logic [CNT_W-1:0]       hold_threshold_r;
  logic [CNT_W-1:0]       repeat_period_r;
  logic                   in_accept;
  logic                   is_tick;
  logic                   is_ack;
  logic                   idx_bad;
  lane_ctl_t              lane_ctl [NUM_BUTTONS];
  lane_res_t              lane_res [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] pressed_mrg;
  logic [NUM_BUTTONS-1:0] long_mrg;
  logic [NUM_BUTTONS-1:0] hit_mrg;

  logic                   out_valid_r, out_valid_nxt;
  logic [NUM_BUTTONS-1:0] pressed_r;
  logic [NUM_BUTTONS-1:0] long_r;
  logic                   hit_r;
  logic                   status_r;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_threshold_r <= HOLD_RESET;
      repeat_period_r  <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HOLD_THRESHOLD: hold_threshold_r <= cfg_wr_data;
        CFG_REPEAT_PERIOD:  repeat_period_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Input handshake and beat decode.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign is_tick   = in_accept & (in_operation == OP_TICK);
  assign is_ack    = in_accept & (in_operation == OP_ACK);
  assign idx_bad   = in_button_index >= IDX_W'(NUM_BUTTONS);

  // One lane per button.
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    assign lane_ctl[b].tick = is_tick;
    assign lane_ctl[b].ack  = is_ack & (in_button_index == IDX_W'(b));

    dbhr_lane u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl            (lane_ctl[b]),
      .pin            (in_raw_levels[b]),
      .hold_threshold (hold_threshold_r),
      .repeat_period  (repeat_period_r),
      .res            (lane_res[b])
    );

    assign pressed_mrg[b] = lane_res[b].pressed;
    assign long_mrg[b]    = lane_res[b].long_hold;
    assign hit_mrg[b]     = lane_res[b].hit;
  end

  // Output register valid: loads on an accepted beat, empties when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Merge stage: gather the lane reports into the result beat.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pressed_r <= pressed_mrg;
      long_r    <= long_mrg;
      hit_r     <= |hit_mrg;
      status_r  <= (in_operation == OP_ACK) & idx_bad;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pressed_bits   = pressed_r;
  assign out_long_hold_bits = long_r;
  assign out_repeat_hit     = hit_r;
  assign out_status         = status_r;

endmodule
